FILE: rtl/core/bf3g_pkg.sv
// Shared types, constants and helpers for the 3x3 box filter.
// No dependencies.
package bf3g_pkg;

  localparam int PIX_W        = 8;
  localparam int KERNEL_SIZE  = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_W_W      = 11;
  localparam int CFG_H_W      = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int ROW_W        = 12;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = 12'd480;

  // register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // window sum and floor(sum / 9) via reciprocal: (s * 3641) >> 15, exact for s < 4096
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 12;
  localparam int RECIP_SH   = 15;
  localparam logic [RECIP_W-1:0] RECIP9 = 12'd3641;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [3*PIX_W-1:0] col_t;

  function automatic logic [SUM_W-1:0] column_sum(input col_t col);
    column_sum = SUM_W'(col[7:0]) + SUM_W'(col[15:8]) + SUM_W'(col[23:16]);
  endfunction

endpackage

FILE: rtl/core/box_filter_3x3_gray.sv
// Top level of the streaming 3x3 box (mean) filter for 8-bit grayscale.
// Depends on bf3g_pkg and bf3g_ram.
//
// Pixels enter in raster order, one transaction per clock when out_ready stays high;
// each pixel is finished in the cycle it is accepted and its result (if any) sits in
// the output register the next cycle. The two previous rows live in one RAM holding
// both lines; its read port is pointed at the next column ahead of time, so the
// registered read data is ready when that column's pixel arrives. Border positions
// produce no result; frame_end marks the last interior result. Width is clamped to
// 3..MAX_WIDTH, height to >= 3. No clearing pass after reset: line buffer contents
// are valid once the first two rows of a frame have been written.
module box_filter_3x3_gray #(
  parameter int MAX_WIDTH = bf3g_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bf3g_pkg::PIX_W-1:0]          in_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bf3g_pkg::PIX_W-1:0]          out_mean_value,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_center_col,
  output logic [bf3g_pkg::ROW_W-1:0]          out_center_row,
  output logic                                out_frame_end,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [bf3g_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EW   = AW + 1;
  localparam int CMPW = 14;
  localparam int RW   = bf3g_pkg::ROW_W;
  localparam int PW   = bf3g_pkg::PIX_W;
  localparam int MW   = bf3g_pkg::SUM_W + bf3g_pkg::RECIP_W;

  logic [bf3g_pkg::CFG_W_W-1:0] width_r;
  logic [bf3g_pkg::CFG_H_W-1:0] height_r;
  logic [AW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  bf3g_pkg::col_t               prev1_r, prev2_r, cur;
  logic                         out_valid_r;
  logic [PW-1:0]                mean_r;
  logic [AW-1:0]                ccol_r;
  logic [RW-1:0]                crow_r;
  logic                         fend_r;

  logic [EW-1:0]                eff_w;
  logic [RW-1:0]                eff_h;
  logic [CMPW-1:0]              w_ext;
  logic [2*PW-1:0]              rd_lines;
  logic                         accept, last_col, last_row, emit;
  logic [bf3g_pkg::SUM_W-1:0]   sum;
  logic [MW-1:0]                prod;

  // effective frame size
  always_comb begin
    w_ext = CMPW'(width_r);
    if (w_ext < CMPW'(bf3g_pkg::KERNEL_SIZE)) begin
      eff_w = EW'(bf3g_pkg::KERNEL_SIZE);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(w_ext);
    end
    if (height_r < bf3g_pkg::CFG_H_W'(bf3g_pkg::KERNEL_SIZE)) begin
      eff_h = RW'(bf3g_pkg::KERNEL_SIZE);
    end else begin
      eff_h = RW'(height_r);
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // rd_lines = {two rows above, row above} at col_r
  assign cur = {rd_lines[2*PW-1:PW], rd_lines[PW-1:0], in_pixel};

  assign last_col = {1'b0, col_r} >= eff_w - EW'(1);
  assign last_row = row_r >= eff_h - RW'(1);
  assign emit = (row_r >= RW'(bf3g_pkg::KERNEL_SIZE - 1)) &&
                (col_r >= AW'(bf3g_pkg::KERNEL_SIZE - 1)) &&
                ({1'b0, col_r} < eff_w) && (row_r < eff_h);

  assign sum  = bf3g_pkg::column_sum(cur) + bf3g_pkg::column_sum(prev1_r) +
                bf3g_pkg::column_sum(prev2_r);
  assign prod = MW'(sum) * MW'(bf3g_pkg::RECIP9);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  bf3g_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data ({rd_lines[PW-1:0], in_pixel}),
    .rd_addr (col_nxt),
    .rd_data (rd_lines)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= bf3g_pkg::WIDTH_RST;
      height_r    <= bf3g_pkg::HEIGHT_RST;
      col_r       <= '0;
      row_r       <= '0;
      prev1_r     <= '0;
      prev2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bf3g_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data[bf3g_pkg::CFG_W_W-1:0];
          bf3g_pkg::CFG_IDX_HEIGHT: height_r <= cfg_data[bf3g_pkg::CFG_H_W-1:0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        prev1_r <= cur;
        prev2_r <= prev1_r;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      mean_r <= prod[bf3g_pkg::RECIP_SH +: PW];
      ccol_r <= col_r - AW'(1);
      crow_r <= row_r - RW'(1);
      fend_r <= last_col && ({1'b0, col_r} == eff_w - EW'(1)) && (row_r == eff_h - RW'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_center_col = ccol_r;
  assign out_center_row = crow_r;
  assign out_frame_end  = fend_r;

endmodule

FILE: rtl/core/bf3g_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf3g_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: dv/box_filter_3x3_gray_tb.sv
// Self-checking testbench for box_filter_3x3_gray: streams raster frames through the
// filter and checks every mean against a cycle-free window predictor kept in step.
// Depends on bf3g_pkg and the box_filter_3x3_gray RTL.
`timescale 1ns / 100ps

module box_filter_3x3_gray_tb;
  import bf3g_pkg::*;

  localparam int MAXW       = MAX_WIDTH_DEF;
  localparam int QUIET_MAX  = 2000;
  localparam int LONG_STALL = 250;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic [9:0]       center_col;
    logic [ROW_W-1:0] center_row;
    logic             frame_end;
  } box_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_mean_value;
  logic [9:0]            out_center_col;
  logic [ROW_W-1:0]      out_center_row;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_IDX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [CFG_W_W-1:0] reg_width = WIDTH_RST;
  logic [CFG_H_W-1:0] reg_height = HEIGHT_RST;
  logic [PIX_W-1:0]   row_up1 [MAXW];
  logic [PIX_W-1:0]   row_up2 [MAXW];
  col_t               win_prev1 = '0;
  col_t               win_prev2 = '0;
  logic [9:0]         pos_col = '0;
  logic [ROW_W-1:0]   pos_row = '0;

  logic [PIX_W-1:0] pix_pending [$];
  box_result_t      mean_expected [$];
  box_result_t      exp_r;
  int               pushed_total = 0;
  int               accepted_cnt = 0;
  int               err_count = 0;
  int               src_mode = 0;
  int               sink_mode = 0;
  int               src_gap = 0;
  int               sink_wait = 0;
  int               taken = 0;
  logic             long_hold_done = 1'b0;
  int               quiet_cycles = 0;

  box_filter_3x3_gray uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_value (out_mean_value),
    .out_center_col (out_center_col),
    .out_center_row (out_center_row),
    .out_frame_end  (out_frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_width();
    if (reg_width < KERNEL_SIZE) return KERNEL_SIZE;
    if (reg_width > MAXW) return MAXW;
    return reg_width;
  endfunction

  function automatic int eff_height();
    if (reg_height < KERNEL_SIZE) return KERNEL_SIZE;
    return reg_height;
  endfunction

  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // one pixel through the window: expected mean for interior centres, then shift state
  function automatic void box_mean_step(input logic [PIX_W-1:0] px);
    int w, h, s, k;
    col_t cur;
    box_result_t r;
    w = eff_width();
    h = eff_height();
    cur = {row_up2[pos_col], row_up1[pos_col], px};
    if (pos_row >= 2 && pos_col >= 2 && pos_col < w && pos_row < h) begin
      s = 0;
      for (k = 0; k < 3; k++)
        s = s + int'(cur[8*k +: 8]) + int'(win_prev1[8*k +: 8]) + int'(win_prev2[8*k +: 8]);
      r.mean_value = PIX_W'(s / 9);
      r.center_col = 10'(pos_col - 1);
      r.center_row = ROW_W'(pos_row - 1);
      r.frame_end  = (pos_col == w - 1) && (pos_row == h - 1);
      mean_expected.push_back(r);
    end
    row_up2[pos_col] = row_up1[pos_col];
    row_up1[pos_col] = px;
    win_prev2 = win_prev1;
    win_prev1 = cur;
    if (pos_col >= w - 1) begin
      pos_col = '0;
      if (pos_row >= h - 1) pos_row = '0;
      else pos_row = pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endfunction

  function automatic int pixels_to_frame_end();
    int c, r, n;
    c = pos_col;
    r = pos_row;
    n = 0;
    while (c != 0 || r != 0) begin
      n++;
      if (c >= eff_width() - 1) begin
        c = 0;
        r = (r >= eff_height() - 1) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  task automatic queue_pixel(input logic [PIX_W-1:0] p);
    pix_pending.push_back(p);
    pushed_total++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pixel(rand_pixel());
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_total || mean_expected.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) reg_width = d[CFG_W_W-1:0];
    else reg_height = d[CFG_H_W-1:0];
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pix_pending.size() != 0) begin
        in_valid <= 1'b1;
        in_pixel <= pix_pending.pop_front();
        src_gap <= draw_gap(src_mode);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the pipe up
  always @(posedge clk) begin : sink
    int hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
      taken <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken <= taken + 1;
      if (sink_wait != 0) begin
        out_ready <= 1'b0;
        sink_wait <= sink_wait - 1;
      end else if (!long_hold_done && taken >= 30 && pix_pending.size() >= 64) begin
        out_ready <= 1'b0;
        sink_wait <= LONG_STALL;
        long_hold_done <= 1'b1;
      end else if (out_valid && out_ready) begin
        hold = draw_gap(sink_mode);
        out_ready <= (hold == 0);
        sink_wait <= (hold == 0) ? 0 : hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // checker first, then predict the transaction accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (mean_expected.size() == 0) begin
          $error("unexpected result: mean_value %0d center_col %0d center_row %0d",
                 out_mean_value, out_center_col, out_center_row);
          err_count++;
        end else begin
          exp_r = mean_expected.pop_front();
          if (out_mean_value !== exp_r.mean_value) begin
            $error("mean_value: expected %0d, actual %0d", exp_r.mean_value, out_mean_value);
            err_count++;
          end
          if (out_center_col !== exp_r.center_col) begin
            $error("center_col: expected %0d, actual %0d", exp_r.center_col, out_center_col);
            err_count++;
          end
          if (out_center_row !== exp_r.center_row) begin
            $error("center_row: expected %0d, actual %0d", exp_r.center_row, out_center_row);
            err_count++;
          end
          if (out_frame_end !== exp_r.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", exp_r.frame_end, out_frame_end);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        accepted_cnt++;
        box_mean_step(in_pixel);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n, k, w, h;
    for (k = 0; k < MAXW; k++) begin
      row_up1[k] = '0;
      row_up2[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // smallest frame from clamped settings: all white, then all black
    write_reg(CFG_IDX_WIDTH, 12'd0);
    write_reg(CFG_IDX_HEIGHT, 12'd0);
    repeat (9) queue_pixel(8'hFF);
    settle();
    write_reg(CFG_IDX_WIDTH, 12'd2);
    write_reg(CFG_IDX_HEIGHT, 12'd2);
    repeat (9) queue_pixel(8'h00);
    settle();

    // widest row; width clamps to the line buffer depth, then shrinks mid-frame
    write_reg(CFG_IDX_WIDTH, 12'hFFF);
    write_reg(CFG_IDX_HEIGHT, 12'd3);
    queue_random(MAXW + 1);
    settle();
    write_reg(CFG_IDX_WIDTH, 12'd4);
    queue_random(pixels_to_frame_end());
    settle();

    // tallest height, then shrink both mid-row so the counters wrap
    src_mode = 1;
    sink_mode = 1;
    write_reg(CFG_IDX_WIDTH, 12'd5);
    write_reg(CFG_IDX_HEIGHT, 12'hFFF);
    queue_random(5 * 6 + 4);
    settle();
    write_reg(CFG_IDX_WIDTH, 12'd3);
    write_reg(CFG_IDX_HEIGHT, 12'd3);
    queue_random(pixels_to_frame_end() + 9);
    settle();

    while (pushed_total < 1950) begin
      settle();
      src_mode = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      k = $urandom_range(0, 9);
      w = (k == 0) ? $urandom_range(0, 2) : (k < 3) ? 3 : $urandom_range(4, 16);
      k = $urandom_range(0, 9);
      h = (k == 0) ? $urandom_range(0, 2) : (k < 3) ? 3 : $urandom_range(4, 10);
      write_reg(CFG_IDX_WIDTH, {1'($urandom_range(0, 1)), 11'(w)});
      write_reg(CFG_IDX_HEIGHT, 12'(h));
      queue_random(eff_width() * eff_height() * $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) begin
        // break into a frame: width may only shrink there, height may go anywhere
        queue_random($urandom_range(1, eff_width() * eff_height() - 1));
        settle();
        if ($urandom_range(0, 1))
          write_reg(CFG_IDX_HEIGHT, 12'($urandom_range(0, 12)));
        else
          write_reg(CFG_IDX_WIDTH, {1'b0, 11'($urandom_range(0, eff_width()))});
        queue_random($urandom_range(0, 20));
        settle();
        n = pixels_to_frame_end();
        queue_random(n);
      end
    end
    settle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bf3g_pkg.sv
rtl/core/bf3g_ram.sv
rtl/core/box_filter_3x3_gray.sv
dv/box_filter_3x3_gray_tb.sv
